// ===== hdl/i2c_pkg.sv =====
// Shared constants and types for the im2col unfold address generator.
// No dependencies; imported by the top level.
package i2c_pkg;

  localparam int SPATIAL_BITS_DEF = 16;
  localparam int KERNEL_BITS_DEF  = 8;

  localparam int INDEX_W   = 48;
  localparam int COORD_W   = 16;
  localparam int DEST_W    = 32;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BATCH_COUNT   = 3'd0,
    CFG_CHANNEL_COUNT = 3'd1,
    CFG_INPUT_DIMS    = 3'd2,
    CFG_WINDOW_GRID   = 3'd3,
    CFG_KERNEL_DIMS   = 3'd4,
    CFG_STRIDE_PAIR   = 3'd5,
    CFG_PADDING_PAIR  = 3'd6,
    CFG_DILATION_PAIR = 3'd7
  } cfg_reg_t;

endpackage

// ===== hdl/i2c_divpipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a sideband word alongside; no package dependencies.
module i2c_divpipe #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem,
  output logic [SW-1:0] side_out
);

  logic          vld_r  [NW];
  logic [DW-1:0] rem_r  [NW];
  logic [NW-1:0] acc_r  [NW];
  logic [SW-1:0] side_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] r_in;
    logic [NW-1:0] a_in;
    logic [SW-1:0] s_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;
    logic [DW-1:0] rem_nxt;
    logic [NW-1:0] acc_nxt;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = '0;
      assign a_in = dividend;
      assign s_in = side_in;
    end else begin : g_next
      assign v_in = vld_r[k-1];
      assign r_in = rem_r[k-1];
      assign a_in = acc_r[k-1];
      assign s_in = side_r[k-1];
    end

    assign trial   = {r_in, a_in[NW-1]};
    assign take    = trial >= {1'b0, divisor};
    assign diff    = trial - {1'b0, divisor};
    assign rem_nxt = take ? diff[DW-1:0] : trial[DW-1:0];
    assign acc_nxt = {a_in[NW-2:0], take};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        acc_r[k]  <= acc_nxt;
        side_r[k] <= s_in;
      end
    end
  end

  assign out_valid = vld_r[NW-1];
  assign quot      = acc_r[NW-1];
  assign rem       = rem_r[NW-1];
  assign side_out  = side_r[NW-1];

endmodule

// ===== hdl/im2col_address_generator_top.sv =====
// Top level of the im2col unfold address generator: configuration registers,
// divider chain and coordinate arithmetic. Depends on i2c_pkg and i2c_divpipe.
//
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready   | in_out_index
// out     | output    | out_valid / out_ready | batch, channel, source, dest, zero fill
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request enters per cycle unless the output stalls or a configuration write holds it off; a result
// passes through the five bit-serial divider pipelines, then the product, sum and output registers.
// Reset clears the valid bits and loads the default configuration.
// A stall on the output freezes every stage through one common enable.
// The input is held off after reset and in the cycle after each configuration write.
module im2col_address_generator_top #(
  parameter int SPATIAL_BITS = i2c_pkg::SPATIAL_BITS_DEF,
  parameter int KERNEL_BITS  = i2c_pkg::KERNEL_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [i2c_pkg::INDEX_W-1:0]     in_out_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [i2c_pkg::COORD_W-1:0]     out_batch_idx,
  output logic [i2c_pkg::COORD_W-1:0]     out_chan_idx,
  output logic [i2c_pkg::COORD_W-1:0]     out_src_row,
  output logic [i2c_pkg::COORD_W-1:0]     out_src_col,
  output logic [i2c_pkg::DEST_W-1:0]      out_dest_row,
  output logic [i2c_pkg::DEST_W-1:0]      out_dest_col,
  output logic                            out_zero_fill,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [i2c_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [((2*SPATIAL_BITS > 2*KERNEL_BITS) ?
                 ((2*SPATIAL_BITS > 16) ? 2*SPATIAL_BITS : 16) :
                 ((2*KERNEL_BITS > 16) ? 2*KERNEL_BITS : 16))-1:0] cfg_data
);
  import i2c_pkg::*;

  localparam int SB  = SPATIAL_BITS;
  localparam int KB  = KERNEL_BITS;
  localparam int VW  = ((SB + KB > 2*KB) ? SB + KB : 2*KB) + 1;
  localparam int DRW = COORD_W + 2*KB + 1;
  localparam int S2  = 1 + 2*SB;
  localparam int S3  = 1 + 2*SB + 2*KB;
  localparam int S4  = 2 + 2*COORD_W + 2*KB + 2*SB;
  localparam int S5  = S4 + 2*SB;

  logic [COORD_W-1:0] batch_r;
  logic [COORD_W-1:0] chan_r;
  logic [2*SB-1:0]    indim_r;
  logic [2*SB-1:0]    wgrid_r;
  logic [2*KB-1:0]    kdim_r;
  logic [2*KB-1:0]    stride_r;
  logic [2*KB-1:0]    pad_r;
  logic [2*KB-1:0]    dil_r;
  logic               cfg_hold_r;

  logic [SB-1:0] h_dim, w_dim, lh_dim, lw_dim;
  logic [KB-1:0] kh_dim, kw_dim, sh, sw, ph, pw, dh, dw;

  logic [2*SB-1:0] l_area_r;
  logic [2*KB-1:0] p_area_r;
  logic            empty_r;
  logic            en;

  assign h_dim  = indim_r[2*SB-1:SB];
  assign w_dim  = indim_r[SB-1:0];
  assign lh_dim = wgrid_r[2*SB-1:SB];
  assign lw_dim = wgrid_r[SB-1:0];
  assign kh_dim = kdim_r[2*KB-1:KB];
  assign kw_dim = kdim_r[KB-1:0];
  assign sh     = stride_r[2*KB-1:KB];
  assign sw     = stride_r[KB-1:0];
  assign ph     = pad_r[2*KB-1:KB];
  assign pw     = pad_r[KB-1:0];
  assign dh     = dil_r[2*KB-1:KB];
  assign dw     = dil_r[KB-1:0];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_r    <= COORD_W'(1);
      chan_r     <= COORD_W'(1);
      indim_r    <= {SB'(1), SB'(1)};
      wgrid_r    <= {SB'(1), SB'(1)};
      kdim_r     <= {KB'(1), KB'(1)};
      stride_r   <= {KB'(1), KB'(1)};
      pad_r      <= '0;
      dil_r      <= {KB'(1), KB'(1)};
      cfg_hold_r <= 1'b1;
    end else begin
      cfg_hold_r <= cfg_valid;
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_BATCH_COUNT:   batch_r  <= cfg_data[COORD_W-1:0];
          CFG_CHANNEL_COUNT: chan_r   <= cfg_data[COORD_W-1:0];
          CFG_INPUT_DIMS:    indim_r  <= cfg_data[2*SB-1:0];
          CFG_WINDOW_GRID:   wgrid_r  <= cfg_data[2*SB-1:0];
          CFG_KERNEL_DIMS:   kdim_r   <= cfg_data[2*KB-1:0];
          CFG_STRIDE_PAIR:   stride_r <= cfg_data[2*KB-1:0];
          CFG_PADDING_PAIR:  pad_r    <= cfg_data[2*KB-1:0];
          CFG_DILATION_PAIR: dil_r    <= cfg_data[2*KB-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    l_area_r <= lh_dim * lw_dim;
    p_area_r <= kh_dim * kw_dim;
    empty_r  <= (chan_r == '0) || (kh_dim == '0) || (kw_dim == '0) ||
                (lh_dim == '0) || (lw_dim == '0);
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en && !cfg_hold_r;

  // Divider chain: index / L, then / P, then / C, then window and kernel splits.
  logic              d1_v;
  logic [INDEX_W-1:0] d1_q;
  logic [2*SB-1:0]   d1_r;
  logic              d1_s;

  i2c_divpipe #(.NW(INDEX_W), .DW(2*SB), .SW(1)) u_div_l (
    .clk, .rst_n, .en,
    .in_valid (in_valid && in_ready),
    .dividend (in_out_index),
    .divisor  (l_area_r),
    .side_in  (empty_r),
    .out_valid(d1_v), .quot(d1_q), .rem(d1_r), .side_out(d1_s)
  );

  logic              d2_v;
  logic [INDEX_W-1:0] d2_q;
  logic [2*KB-1:0]   d2_r;
  logic [S2-1:0]     d2_s;

  i2c_divpipe #(.NW(INDEX_W), .DW(2*KB), .SW(S2)) u_div_p (
    .clk, .rst_n, .en,
    .in_valid (d1_v),
    .dividend (d1_q),
    .divisor  (p_area_r),
    .side_in  ({d1_s, d1_r}),
    .out_valid(d2_v), .quot(d2_q), .rem(d2_r), .side_out(d2_s)
  );

  logic              d3_v;
  logic [INDEX_W-1:0] d3_q;
  logic [COORD_W-1:0] d3_r;
  logic [S3-1:0]     d3_s;
  logic              d3_empty;
  logic [2*SB-1:0]   d3_l;
  logic [2*KB-1:0]   d3_p;
  logic              d3_nbad;

  i2c_divpipe #(.NW(INDEX_W), .DW(COORD_W), .SW(S3)) u_div_c (
    .clk, .rst_n, .en,
    .in_valid (d2_v),
    .dividend (d2_q),
    .divisor  (chan_r),
    .side_in  ({d2_s, d2_r}),
    .out_valid(d3_v), .quot(d3_q), .rem(d3_r), .side_out(d3_s)
  );

  assign {d3_empty, d3_l, d3_p} = d3_s;
  assign d3_nbad = d3_q >= INDEX_W'(batch_r);

  logic            d4_v;
  logic [2*SB-1:0] d4_q;
  logic [SB-1:0]   d4_r;
  logic [S4-1:0]   d4_s;
  logic [2*KB-1:0] d4_p;

  i2c_divpipe #(.NW(2*SB), .DW(SB), .SW(S4)) u_div_lw (
    .clk, .rst_n, .en,
    .in_valid (d3_v),
    .dividend (d3_l),
    .divisor  (lw_dim),
    .side_in  ({d3_empty, d3_nbad, d3_q[COORD_W-1:0], d3_r, d3_p, d3_l}),
    .out_valid(d4_v), .quot(d4_q), .rem(d4_r), .side_out(d4_s)
  );

  assign d4_p = d4_s[2*SB +: 2*KB];

  logic               d5_v;
  logic [2*KB-1:0]    d5_q;
  logic [KB-1:0]      d5_r;
  logic [S5-1:0]      d5_s;
  logic               d5_empty, d5_nbad;
  logic [COORD_W-1:0] d5_n, d5_c;
  logic [2*KB-1:0]    d5_p;
  logic [2*SB-1:0]    d5_l;
  logic [SB-1:0]      d5_lh, d5_lw;

  i2c_divpipe #(.NW(2*KB), .DW(KB), .SW(S5)) u_div_kw (
    .clk, .rst_n, .en,
    .in_valid (d4_v),
    .dividend (d4_p),
    .divisor  (kw_dim),
    .side_in  ({d4_s, d4_q[SB-1:0], d4_r}),
    .out_valid(d5_v), .quot(d5_q), .rem(d5_r), .side_out(d5_s)
  );

  assign {d5_empty, d5_nbad, d5_n, d5_c, d5_p, d5_l, d5_lh, d5_lw} = d5_s;

  // Products, then sums, then the bounds check into the output register.
  logic                     m1_v_r, m1_ok_r;
  logic [COORD_W-1:0]       m1_n_r, m1_c_r;
  logic [2*KB-1:0]          m1_p_r;
  logic [2*SB-1:0]          m1_l_r;
  logic [SB+KB-1:0]         m1_lhsh_r, m1_lwsw_r;
  logic [2*KB-1:0]          m1_khdh_r, m1_kwdw_r;
  logic [COORD_W+2*KB-1:0]  m1_cp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= d5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_ok_r   <= !d5_empty && !d5_nbad;
      m1_n_r    <= d5_n;
      m1_c_r    <= d5_c;
      m1_p_r    <= d5_p;
      m1_l_r    <= d5_l;
      m1_lhsh_r <= d5_lh * sh;
      m1_lwsw_r <= d5_lw * sw;
      m1_khdh_r <= d5_q[KB-1:0] * dh;
      m1_kwdw_r <= d5_r * dw;
      m1_cp_r   <= d5_c * p_area_r;
    end
  end

  logic               m2_v_r, m2_ok_r;
  logic [COORD_W-1:0] m2_n_r, m2_c_r;
  logic [VW-1:0]      m2_vh_r, m2_vw_r;
  logic [DEST_W-1:0]  m2_drow_r, m2_dcol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (en) begin
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_ok_r   <= m1_ok_r;
      m2_n_r    <= m1_n_r;
      m2_c_r    <= m1_c_r;
      m2_vh_r   <= VW'(m1_lhsh_r) + VW'(m1_khdh_r);
      m2_vw_r   <= VW'(m1_lwsw_r) + VW'(m1_kwdw_r);
      m2_drow_r <= DEST_W'(DRW'(m1_cp_r) + DRW'(m1_p_r));
      m2_dcol_r <= DEST_W'(m1_l_r);
    end
  end

  logic          inside_img;
  logic [VW-1:0] h_off, w_off;

  assign h_off      = m2_vh_r - VW'(ph);
  assign w_off      = m2_vw_r - VW'(pw);
  assign inside_img = (m2_vh_r >= VW'(ph)) && (m2_vw_r >= VW'(pw)) &&
                      (h_off < VW'(h_dim)) && (w_off < VW'(w_dim));

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m2_v_r && m2_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_batch_idx <= m2_n_r;
      out_chan_idx  <= m2_c_r;
      out_src_row   <= inside_img ? COORD_W'(h_off) : '0;
      out_src_col   <= inside_img ? COORD_W'(w_off) : '0;
      out_dest_row  <= m2_drow_r;
      out_dest_col  <= m2_dcol_r;
      out_zero_fill <= !inside_img;
    end
  end

  assign out_valid = out_valid_r;

  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> !in_ready)
    else $error("input accepted right after a configuration write");

  a_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_fill |-> out_src_row == '0 && out_src_col == '0)
    else $error("zero-fill result carries nonzero source coordinates");

  a_batch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_batch_idx < batch_r)
    else $error("result batch index at or past batch count");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_zero_fill |-> out_src_row < h_dim && out_src_col < w_dim)
    else $error("source coordinate outside the image");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the im2col unfold address generator.
// It depends on i2c_pkg and im2col_address_generator_top. A scoreboard class predicts each tap.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import i2c_pkg::*;

  typedef struct packed {
    logic [15:0] batch;
    logic [15:0] chan;
    logic [15:0] srow;
    logic [15:0] scol;
    logic [31:0] drow;
    logic [31:0] dcol;
    logic        zf;
  } tap_t;

  class tap_scoreboard;
    logic [15:0] n_cnt, c_cnt;
    logic [31:0] in_dims, win_grid;
    logic [15:0] k_dims, stride, pad, dil;
    tap_t pending[$];
    int errors;

    function void defaults();
      n_cnt = 1; c_cnt = 1; in_dims = 32'h0001_0001; win_grid = 32'h0001_0001;
      k_dims = 16'h0101; stride = 16'h0101; pad = 0; dil = 16'h0101;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] v);
      case (idx)
        CFG_BATCH_COUNT:   n_cnt = v[15:0];
        CFG_CHANNEL_COUNT: c_cnt = v[15:0];
        CFG_INPUT_DIMS:    in_dims = v;
        CFG_WINDOW_GRID:   win_grid = v;
        CFG_KERNEL_DIMS:   k_dims = v[15:0];
        CFG_STRIDE_PAIR:   stride = v[15:0];
        CFG_PADDING_PAIR:  pad = v[15:0];
        CFG_DILATION_PAIR: dil = v[15:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic [47:0] gid);
      longint unsigned kp, lp, ncp, l, nc, p, n, c, vh, vw, kw, lw;
      tap_t t;
      kp = k_dims[15:8] * k_dims[7:0];
      lp = win_grid[31:16] * win_grid[15:0];
      if (c_cnt == 0 || kp == 0 || lp == 0) return;
      ncp = gid / lp; l = gid % lp;
      nc = ncp / kp; p = ncp % kp;
      n = nc / c_cnt; c = nc % c_cnt;
      if (n >= n_cnt) return;
      kw = k_dims[7:0]; lw = win_grid[15:0];
      vh = (l / lw) * stride[15:8] + (p / kw) * dil[15:8];
      vw = (l % lw) * stride[7:0] + (p % kw) * dil[7:0];
      t = '0;
      t.zf = 1;
      if (vh >= pad[15:8] && vw >= pad[7:0] && vh - pad[15:8] < in_dims[31:16]
          && vw - pad[7:0] < in_dims[15:0]) begin
        t.zf = 0; t.srow = vh - pad[15:8]; t.scol = vw - pad[7:0];
      end
      t.batch = n; t.chan = c; t.drow = c * kp + p; t.dcol = l;
      pending.push_back(t);
    endfunction

    function void check_tap(tap_t a);
      tap_t e;
      if (pending.size() == 0) begin
        $error("unexpected result"); errors++; return;
      end
      e = pending.pop_front();
      if (a.batch !== e.batch) begin
        $error("batch_idx exp %0d got %0d", e.batch, a.batch); errors++;
      end
      if (a.chan !== e.chan) begin
        $error("chan_idx exp %0d got %0d", e.chan, a.chan); errors++;
      end
      if (a.srow !== e.srow) begin
        $error("src_row exp %0d got %0d", e.srow, a.srow); errors++;
      end
      if (a.scol !== e.scol) begin
        $error("src_col exp %0d got %0d", e.scol, a.scol); errors++;
      end
      if (a.drow !== e.drow) begin
        $error("dest_row exp %0d got %0d", e.drow, a.drow); errors++;
      end
      if (a.dcol !== e.dcol) begin
        $error("dest_col exp %0d got %0d", e.dcol, a.dcol); errors++;
      end
      if (a.zf !== e.zf) begin
        $error("zero_fill exp %0d got %0d", e.zf, a.zf); errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = 195;

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic [47:0] in_out_index;
  logic [15:0] out_batch_idx, out_chan_idx, out_src_row, out_src_col;
  logic [31:0] out_dest_row, out_dest_col;
  logic out_zero_fill;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  tap_scoreboard sb;
  int hold_off, cycles;
  bit idle_free;

  im2col_address_generator_top u_dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_tap({out_batch_idx, out_chan_idx, out_src_row, out_src_col,
                    out_dest_row, out_dest_col, out_zero_fill});
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 0;
    end else
      out_ready <= idle_free || ($urandom_range(99) >= 28);
  end

  task automatic send_request(logic [47:0] v);
    if (!idle_free) begin
      while ($urandom_range(99) < 28) begin
        in_valid <= 0;
        @(posedge clk);
      end
    end
    in_valid <= 1;
    in_out_index <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_request(v);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic setup(logic [15:0] n, logic [15:0] c, logic [31:0] dims, logic [31:0] win,
                       logic [15:0] k, logic [15:0] s, logic [15:0] p, logic [15:0] d);
    write_reg(CFG_BATCH_COUNT, n);
    write_reg(CFG_CHANNEL_COUNT, c);
    write_reg(CFG_INPUT_DIMS, dims);
    write_reg(CFG_WINDOW_GRID, win);
    write_reg(CFG_KERNEL_DIMS, k);
    write_reg(CFG_STRIDE_PAIR, s);
    write_reg(CFG_PADDING_PAIR, p);
    write_reg(CFG_DILATION_PAIR, d);
  endtask

  task automatic random_phase(int count, longint unsigned span);
    logic [47:0] v;
    repeat (count) begin
      if ($urandom_range(9) == 0) v = {$urandom, $urandom};
      else v = {$urandom, $urandom} % span;
      send_request(v);
    end
  endtask

  initial begin
    sb = new();
    sb.defaults();
    rst_n = 0; in_valid = 0; in_out_index = 0; out_ready = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0; hold_off = 0; idle_free = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reset geometry, then extremes and corner geometries.
    send_request(0); send_request(1); send_request(48'hFFFF_FFFF_FFFF);
    drain();
    setup(3, 2, 32'h0005_0004, 32'h0003_0003, 16'h0303, 16'h0102, 16'h0201, 16'h0201);
    for (int i = 0; i < 10; i++) send_request(i * 17);
    send_request(161); send_request(162);
    drain();
    setup(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
          16'hFFFF, 16'hFFFF);
    send_request(0); send_request(48'hFFFF_FFFF_FFFF); send_request(48'h5555_AAAA_5555);
    drain();
    setup(0, 1, 32'h0000_0003, 32'h0001_0002, 16'h0100, 16'h0101, 0, 16'h0000);
    send_request(0); send_request(3);
    drain();
    write_reg(CFG_KERNEL_DIMS, 16'h0201);
    write_reg(CFG_BATCH_COUNT, 2);
    send_request(0); send_request(5);
    drain();

    // Random: receiver hold-off while requests keep coming, a stall-free phase, other geometries.
    setup(4, 3, 32'h0006_0005, 32'h0004_0003, 16'h0302, 16'h0201, 16'h0102, 16'h0102);
    hold_off = 400;
    random_phase(300, 4 * 3 * 6 * 12 + 20);
    drain();
    setup(2, 5, 32'h0008_0008, 32'h0005_0006, 16'h0203, 16'h0302, 16'h0301, 16'h0203);
    idle_free = 1;
    random_phase(200, 2 * 5 * 6 * 30 + 30);
    idle_free = 0;
    drain();
    setup(16'hFFFF, 16'h1234, {$urandom}, {$urandom}, $urandom, $urandom, $urandom,
          $urandom);
    random_phase(250, 48'hFFFF_FFFF_FFFF);
    drain();
    setup(3, 2, 32'h0000_0004, 32'h0002_0002, 16'h0202, 16'h0101, 16'h0000, 16'h0101);
    random_phase(300, 3 * 2 * 4 * 4 + 10);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/i2c_pkg.sv
hdl/i2c_divpipe.sv
hdl/im2col_address_generator_top.sv
tb/testbench.sv
